/* rtl/core/pcl_pkg.sv */
package pcl_pkg;

    // Request operation codes.
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Response status codes.
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REPEAT = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // Fixed field widths of the two channels.
    localparam int LINE_IN_W  = 32;
    localparam int POS_W      = 32;
    localparam int LINE_OUT_W = 16;
    localparam int STATUS_W   = 2;

    // Result of one request, held until the response register is free.
    typedef struct packed {
        logic [LINE_OUT_W-1:0] line_number;
        logic [STATUS_W-1:0]   status;
    } result_t;

endpackage

/* rtl/core/pcl_req_if.sv */
interface pcl_req_if
    import pcl_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [LINE_IN_W-1:0] line;
    logic [POS_W-1:0]     position;

    modport source (output valid, output op, output line, output position, input ready);
    modport sink   (input valid, input op, input line, input position, output ready);
endinterface

/* rtl/core/pcl_rsp_if.sv */
interface pcl_rsp_if
    import pcl_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [LINE_OUT_W-1:0] line_number;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, output line_number, output status, input ready);
    modport sink   (input valid, input line_number, input status, output ready);
endinterface

/* rtl/core/pc_to_line_map_table.sv */
// Channel | Dir | Payload                              | Handshake
// req     | in  | op, line[31:0], position[31:0]       | valid/ready
// rsp     | out | line_number[15:0], status[1:0]      | valid/ready
//
// A record request passes from the sequencer's idle state to its output
// state, which moves its result into the response register. A query
// fetches the first entry from the entry RAM, makes one compare per stored
// entry through the single read port until the scan stops, and hands off
// the result. An empty table answers a query with no fetch and no scan.
// Reset clears the sequencer, the line registers and the entry count; the
// entry RAM is not cleared, since only entries below the count are ever read.
// A waiting response does not block the next request; a new result waits in
// the sequencer until the response register drains.
module pc_to_line_map_table
    import pcl_pkg::*;
#(
    parameter longint unsigned LINE_LIMIT  = 65535,
    parameter int              TABLE_DEPTH = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    pcl_req_if.sink   req,
    pcl_rsp_if.source rsp
);

    // Stored lines and positions never exceed the limit, so they are kept at
    // the width the limit needs.
    localparam int LW = $clog2(LINE_LIMIT + 64'd1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [LINE_IN_W:0] LIMIT_W = (LINE_IN_W+1)'(LINE_LIMIT);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [LW-1:0]        defined_reg, defined_next;
    logic [LINE_IN_W-1:0] prev_reg, prev_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [POS_W-1:0]     qpos_reg, qpos_next;
    logic [LW-1:0]        found_reg, found_next;
    result_t              result_reg, result_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;

    logic                 req_fire;
    logic                 rec_repeat;
    logic                 rec_range;
    logic                 rec_full;
    logic                 wr_en;
    logic [AW-1:0]        rd_addr;
    logic [2*LW-1:0]      rd_data;
    logic [LW-1:0]        rd_pos;
    logic [LW-1:0]        rd_line;
    logic [CW-1:0]        idx_inc;
    logic                 out_free;

    // Low bits of a stored line, widened or cut to the response width.
    function automatic logic [LINE_OUT_W-1:0] found_ext_of(input logic [LW-1:0] value);
        logic [31:0] wide;
        wide = 32'(value);
        return wide[LINE_OUT_W-1:0];
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // Record checks. A nonzero line equal to the last recorded line is a repeat,
    // which takes priority over the range and full checks.
    assign rec_repeat = (req.line == prev_reg) && (req.line != '0);
    assign rec_range  = ({1'b0, req.position} > LIMIT_W) || ({1'b0, req.line} > LIMIT_W);
    assign rec_full   = (count_reg == CW'(TABLE_DEPTH));
    assign wr_en      = req_fire && (req.op == OP_RECORD)
                        && !rec_repeat && !rec_range && !rec_full;

    // Each entry packs the position in the upper half and the line below it.
    assign rd_pos  = rd_data[2*LW-1:LW];
    assign rd_line = rd_data[LW-1:0];

    // During the scan the RAM is addressed one entry ahead, so a compare
    // completes every cycle.
    assign idx_inc = idx_reg + 1'b1;
    assign rd_addr = (state_reg == S_SCAN) ? idx_inc[AW-1:0] : '0;

    pcl_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (2*LW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data ({req.position[LW-1:0], req.line[LW-1:0]}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        defined_next   = defined_reg;
        prev_next      = prev_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        qpos_next      = qpos_reg;
        found_next     = found_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.op == OP_RECORD)
                    begin
                        // The first nonzero line becomes the defined line,
                        // saturated to the limit.
                        if ((defined_reg == '0) && (req.line != '0))
                        begin
                            if ({1'b0, req.line} > LIMIT_W)
                            begin
                                defined_next = LW'(LINE_LIMIT);
                            end
                            else
                            begin
                                defined_next = req.line[LW-1:0];
                            end
                        end
                        result_next.line_number = '0;
                        if (rec_repeat)
                        begin
                            result_next.status = ST_REPEAT;
                        end
                        else
                        begin
                            prev_next = req.line;
                            if (rec_range)
                            begin
                                result_next.status = ST_RANGE;
                            end
                            else if (rec_full)
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                result_next.status = ST_DONE;
                                count_next         = count_reg + 1'b1;
                            end
                        end
                        state_next = S_OUT;
                    end
                    else
                    begin
                        qpos_next  = req.position;
                        found_next = defined_reg;
                        idx_next   = '0;
                        if (count_reg == '0)
                        begin
                            result_next.line_number = found_ext_of(defined_reg);
                            result_next.status      = ST_DONE;
                            state_next              = S_OUT;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                // Entry zero is being read this cycle.
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                // The scan stops at the first entry above the query or at the
                // last stored entry.
                if (POS_W'(rd_pos) <= qpos_reg)
                begin
                    if (idx_inc == count_reg)
                    begin
                        result_next.line_number = found_ext_of(rd_line);
                        result_next.status      = ST_DONE;
                        state_next              = S_OUT;
                    end
                    else
                    begin
                        found_next = rd_line;
                        idx_next   = idx_inc;
                    end
                end
                else
                begin
                    result_next.line_number = found_ext_of(found_reg);
                    result_next.status      = ST_DONE;
                    state_next              = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = result_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            defined_reg   <= '0;
            prev_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            defined_reg   <= defined_next;
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        qpos_reg   <= qpos_next;
        found_reg  <= found_next;
        result_reg <= result_next;
        out_reg    <= out_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.line_number = out_reg.line_number;
    assign rsp.status      = out_reg.status;

endmodule

/* rtl/core/pcl_entry_ram.sv */
// Simple dual-port entry store: one write port, one read port with registered data.
module pcl_entry_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/sv/line_map_checker.sv */
module line_map_checker
    import pcl_pkg::*;
#(
    parameter longint unsigned LINE_LIMIT  = 65535,
    parameter int              TABLE_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    pcl_req_if   req,
    pcl_rsp_if   rsp,
    output int   mismatch_count,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LINE_IN_W-1:0]  defined_line;
    logic [LINE_IN_W-1:0]  last_kept_line;
    logic [POS_W-1:0]      entry_position [TABLE_DEPTH];
    logic [LINE_IN_W-1:0]  entry_line [TABLE_DEPTH];
    int unsigned           entry_count;
    result_t               expected_results [$];

    // Applies a record request to the map and returns its status.
    function automatic logic [STATUS_W-1:0] record_line(input logic [LINE_IN_W-1:0] line,
                                                        input logic [POS_W-1:0] position);
        if (defined_line == '0 && line != '0)
        begin
            defined_line = (line > LINE_LIMIT) ? LINE_IN_W'(LINE_LIMIT) : line;
        end
        if (line == last_kept_line && line != '0)
        begin
            return ST_REPEAT;
        end
        last_kept_line = line;
        if (position > LINE_LIMIT || line > LINE_LIMIT)
        begin
            return ST_RANGE;
        end
        if (entry_count >= TABLE_DEPTH)
        begin
            return ST_FULL;
        end
        entry_position[entry_count] = position;
        entry_line[entry_count]     = line;
        entry_count++;
        return ST_DONE;
    endfunction

    // Walks the entries in order, keeping each line whose position is not above
    // the queried one, and stops at the first entry above it.
    function automatic logic [LINE_OUT_W-1:0] lookup_line(input logic [POS_W-1:0] position);
        logic [LINE_IN_W-1:0] found;
        found = defined_line;
        for (int i = 0; i < entry_count; i++)
        begin
            if (entry_position[i] <= position)
            begin
                found = entry_line[i];
            end
            else
            begin
                break;
            end
        end
        return found[LINE_OUT_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            defined_line   = '0;
            last_kept_line = '0;
            entry_count    = 0;
            mismatch_count = 0;
            pending        = 0;
            expected_results.delete();
        end
        else
        begin
            // Responses first, so that a request accepted at this edge can
            // never be matched by a response accepted at the same edge.
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected response, actual line_number=%0d status=%0d",
                             $time, rsp.line_number, rsp.status);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.line_number !== want.line_number)
                    begin
                        $display("%0t: line_number mismatch, expected %0d, actual %0d",
                                 $time, want.line_number, rsp.line_number);
                        mismatch_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, rsp.status);
                        mismatch_count++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                want.line_number = '0;
                want.status      = ST_DONE;
                if (req.op == OP_QUERY)
                begin
                    want.line_number = lookup_line(req.position);
                end
                else
                begin
                    want.status = record_line(req.line, req.position);
                end
                expected_results.push_back(want);
            end
            pending = expected_results.size();
        end
    end

endmodule

/* tb/sv/tb_pc_to_line_map_table.sv */
module tb_pc_to_line_map_table;
    timeunit 1ns;
    timeprecision 1ps;

    import pcl_pkg::*;

    localparam longint unsigned MAP_LINE_LIMIT  = 65535;
    localparam int              MAP_DEPTH       = 256;
    // Number of random requests after the directed part.
    localparam int              RANDOM_REQUESTS = 1830;
    // Extra wait after the checker's queue of expected results has emptied.
    localparam int              DRAIN_CYCLES    = 300;
    // Length of the one long response hold-off.
    localparam int              HOLD_CYCLES     = 1500;
    // Watchdog limit for the whole run, in nanoseconds.
    localparam longint          TIMEOUT_NS      = 64'd24_000_000;

    logic clk;
    logic rst_n;

    pcl_req_if req_ch ();
    pcl_rsp_if rsp_ch ();

    int mismatch_count;
    int pending;

    // Set when the random part starts; the receiver uses it to place its
    // long hold-off while the sender is still busy.
    bit random_phase;

    // Sender burst bookkeeping and the state used to shape record requests.
    int                   burst_left;
    logic [POS_W-1:0]     cursor_position;
    logic [LINE_IN_W-1:0] recent_line;

    pc_to_line_map_table #(
        .LINE_LIMIT  (MAP_LINE_LIMIT),
        .TABLE_DEPTH (MAP_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    line_map_checker #(
        .LINE_LIMIT  (MAP_LINE_LIMIT),
        .TABLE_DEPTH (MAP_DEPTH)
    ) checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Offers one request and returns at the edge where it is accepted. The
    // sender works in bursts; between bursts valid drops for a random gap,
    // and some bursts follow each other with no gap at all.
    task automatic send_request(input logic op, input logic [LINE_IN_W-1:0] line,
                                input logic [POS_W-1:0] position);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.line     <= line;
        req_ch.position <= position;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
    endtask

    // One random request. Most records are well formed: positions climb in
    // small steps and lines are fresh and in range, so the table fills
    // gradually and later queries scan long runs. The rest are repeated
    // lines, zero lines, out of range values, positions that go backward and
    // plain noise. Queries mostly land inside the recorded positions.
    task automatic send_random_request();
        int                   pick;
        logic [LINE_IN_W-1:0] line;
        logic [POS_W-1:0]     position;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            pick     = $urandom_range(0, 99);
            position = cursor_position + $urandom_range(0, 40);
            if (recent_line < 65000)
            begin
                line = recent_line + $urandom_range(1, 3);
            end
            else
            begin
                line = $urandom_range(1, 100);
            end
            if (pick < 60)
            begin
                // Well-formed step: keep both values as generated.
            end
            else if (pick < 70)
            begin
                line = recent_line;
            end
            else if (pick < 78)
            begin
                line = '0;
            end
            else if (pick < 84)
            begin
                line = $urandom;
            end
            else if (pick < 89)
            begin
                position = $urandom | 32'h0001_0000;
            end
            else if (pick < 94)
            begin
                position = $urandom_range(0, cursor_position);
            end
            else
            begin
                line     = $urandom;
                position = $urandom;
            end
            if (position <= MAP_LINE_LIMIT && position > cursor_position)
            begin
                cursor_position = position;
            end
            recent_line = line;
            send_request(OP_RECORD, line, position);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                position = $urandom_range(0, cursor_position + 50);
            end
            else if (pick < 80)
            begin
                position = '0;
            end
            else if (pick < 90)
            begin
                position = cursor_position;
            end
            else
            begin
                position = $urandom;
            end
            // The line field is ignored by queries but still toggled.
            send_request(OP_QUERY, $urandom, position);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.op       <= OP_RECORD;
        req_ch.line     <= '0;
        req_ch.position <= '0;
        random_phase    = 1'b0;
        burst_left      = 0;
        cursor_position = 100;
        recent_line     = 300;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Queries on an empty table return the defined line, still zero.
        send_request(OP_QUERY, '0, '0);
        send_request(OP_QUERY, '1, '1);
        // Zero lines never define the line and are never repeats.
        send_request(OP_RECORD, '0, 32'd5);
        send_request(OP_RECORD, '0, 32'd6);
        // Query below the first entry falls back to the defined line.
        send_request(OP_QUERY, '0, 32'd4);
        // A wide first line saturates the defined line and is out of range.
        send_request(OP_RECORD, 32'd70000, 32'd10);
        // The repeat test wins over the range test.
        send_request(OP_RECORD, 32'd70000, 32'd11);
        send_request(OP_RECORD, 32'd100, '1);
        send_request(OP_RECORD, 32'd100, 32'd20);
        // Both values at the limit are still stored.
        send_request(OP_RECORD, 32'd65535, 32'd65535);
        send_request(OP_RECORD, 32'd65536, '0);
        send_request(OP_RECORD, '1, '1);
        // A position that goes backward is stored as it comes.
        send_request(OP_RECORD, 32'd200, 32'd3);
        // The defined line is kept once set.
        send_request(OP_RECORD, 32'd7, 32'd100);
        send_request(OP_QUERY, '0, 32'd5);
        send_request(OP_QUERY, '0, 32'd6);
        send_request(OP_QUERY, '0, 32'd65535);
        send_request(OP_QUERY, '0, '1);
        send_request(OP_QUERY, '0, 32'd4);
        send_request(OP_QUERY, '1, '0);

        random_phase = 1'b1;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            send_random_request();
        end
        req_ch.valid <= 1'b0;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Response side. The ready rate is redrawn at the end of each mode of
    // random length, from always ready to mostly stalled. Once the random
    // part is under way the receiver holds off for a long stretch so that
    // the result registers fill and the request side backs up.
    initial
    begin
        int  ready_pct;
        int  mode_left;
        bit  hold_done;
        rsp_ch.ready <= 1'b0;
        ready_pct = 100;
        mode_left = 1;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (random_phase && !hold_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            mode_left--;
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       ready_pct = 100;
                    1:       ready_pct = 80;
                    2:       ready_pct = 50;
                    3:       ready_pct = 20;
                    default: ready_pct = 5;
                endcase
                mode_left = $urandom_range(64, 400);
            end
            rsp_ch.ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

/* pc_to_line_map_table.f */
rtl/core/pcl_pkg.sv
rtl/core/pcl_req_if.sv
rtl/core/pcl_rsp_if.sv
rtl/core/pcl_entry_ram.sv
rtl/core/pc_to_line_map_table.sv
tb/sv/line_map_checker.sv
tb/sv/tb_pc_to_line_map_table.sv
